// ----- rtl/core/sensor_word_crc_check_and_scale_macros.svh -----
// Assertion macros shared by the checking code of the block
`ifndef SENSOR_WORD_CRC_CHECK_AND_SCALE_MACROS_SVH
`define SENSOR_WORD_CRC_CHECK_AND_SCALE_MACROS_SVH

// Same-cycle implication
`define SCWC_ASSERT_NOW(label, clk, rst, cond, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
    else $error("scwc: same-cycle check failed");

// Next-cycle implication
`define SCWC_ASSERT_NEXT(label, clk, rst, cond, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
    else $error("scwc: next-cycle check failed");

`endif

// ----- rtl/core/scwc_pkg.sv -----
`default_nettype none
package scwc_pkg;

  localparam logic [7:0]  CRC_INIT       = 8'hFF;
  localparam logic [7:0]  CRC_POLY_RESET = 8'h31;
  localparam logic [14:0] TEMP_SPAN      = 15'd17500;
  localparam logic [14:0] HUM_SPAN       = 15'd10000;
  localparam logic [14:0] TEMP_OFFSET    = 15'd4500;

  typedef enum logic {
    ACT_TEMP = 1'b0,
    ACT_HUM  = 1'b1
  } action_t;

  typedef struct packed {
    logic        action;
    logic        crc_ok;
    logic [15:0] raw;
  } word_t;

  function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in,
                                           input logic [7:0] data,
                                           input logic [7:0] poly);
    logic [7:0] c;
    c = crc_in ^ data;
    for (int k = 0; k < 8; k++) begin
      c = c[7] ? ({c[6:0], 1'b0} ^ poly) : {c[6:0], 1'b0};
    end
    return c;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/core/scwc_in_if.sv -----
`default_nettype none
interface scwc_in_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] data_high_byte;
  logic [7:0] data_low_byte;
  logic [7:0] crc_byte;

  modport source (output valid, action, data_high_byte, data_low_byte, crc_byte,
                  input ready);
  modport sink (input valid, action, data_high_byte, data_low_byte, crc_byte,
                output ready);
endinterface
`default_nettype wire

// ----- rtl/core/scwc_out_if.sv -----
`default_nettype none
interface scwc_out_if;
  logic               valid;
  logic               ready;
  logic               crc_ok;
  logic [15:0]        raw_word;
  logic signed [14:0] scaled_hundredths;

  modport source (output valid, crc_ok, raw_word, scaled_hundredths,
                  input ready);
  modport sink (input valid, crc_ok, raw_word, scaled_hundredths,
                output ready);
endinterface
`default_nettype wire

// ----- rtl/core/sensor_word_crc_check_and_scale.sv -----
// Checks a 3-byte sensor frame (high byte, low byte, CRC-8 byte; init 0xFF, MSB first,
// polynomial from the register, 0x31 after reset) and scales the 16-bit word to
// hundredths of a degree Celsius or of a percent humidity; a failed check forces the
// word to zero. Four register stages (CRC high byte, CRC low byte and compare,
// span multiply, floor and offset) carry each frame to the output in that order, and
// one frame is taken every cycle while the result side keeps up.
// Write the polynomial only while no frame is in flight.
`default_nettype none
`include "sensor_word_crc_check_and_scale_macros.svh"
module sensor_word_crc_check_and_scale
  import scwc_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  cfg_wr_en,
  input  wire logic  [7:0] cfg_wr_data,
  scwc_in_if.sink    frame,
  scwc_out_if.source result
);

  logic [7:0] poly_reg;
  word_t      mid;
  logic       mid_valid;
  logic       mid_ready;
  logic       out_fail;
  logic       out_zero_word;
  logic       scale_at_zero;

  always_ff @(posedge clk) begin
    if (rst) begin
      poly_reg <= CRC_POLY_RESET;
    end else if (cfg_wr_en) begin
      poly_reg <= cfg_wr_data;
    end
  end

  scwc_crc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .poly      (poly_reg),
    .frame     (frame),
    .mid       (mid),
    .mid_valid (mid_valid),
    .mid_ready (mid_ready)
  );

  scwc_scale u_scale (
    .clk       (clk),
    .rst       (rst),
    .mid       (mid),
    .mid_valid (mid_valid),
    .mid_ready (mid_ready),
    .result    (result)
  );

  assign out_fail      = result.valid && !result.crc_ok;
  assign out_zero_word = result.valid && (result.raw_word == 16'd0);
  assign scale_at_zero = (result.scaled_hundredths == -15'sd4500) ||
                         (result.scaled_hundredths == 15'sd0);

  `SCWC_ASSERT_NOW(a_mid_fail_zero, clk, rst, mid_valid && !mid.crc_ok, mid.raw == 16'd0)
  `SCWC_ASSERT_NOW(a_out_fail_zero, clk, rst, out_fail, result.raw_word == 16'd0)
  `SCWC_ASSERT_NOW(a_zero_word_scale, clk, rst, out_zero_word, scale_at_zero)
  `SCWC_ASSERT_NEXT(a_mid_hold, clk, rst, mid_valid && !mid_ready, mid_valid && $stable(mid))

endmodule
`default_nettype wire

// ----- rtl/core/scwc_crc_front.sv -----
`default_nettype none
module scwc_crc_front
  import scwc_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  [7:0] poly,
  scwc_in_if.sink    frame,
  output word_t      mid,
  output logic       mid_valid,
  input  wire logic  mid_ready
);

  logic       s1_valid;
  logic       s1_action;
  logic [7:0] s1_high;
  logic [7:0] s1_low;
  logic [7:0] s1_check;
  logic [7:0] s1_crc;
  logic       s1_ready;
  logic       s2_ready;
  logic [7:0] crc_full;

  assign s2_ready    = !mid_valid || mid_ready;
  assign s1_ready    = !s1_valid || s2_ready;
  assign frame.ready = s1_ready;
  assign crc_full    = crc8_byte(s1_crc, s1_low, poly);

  // CRC over the high byte
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_ready) begin
      s1_valid <= frame.valid;
    end
    if (s1_ready && frame.valid) begin
      s1_action <= frame.action;
      s1_high   <= frame.data_high_byte;
      s1_low    <= frame.data_low_byte;
      s1_check  <= frame.crc_byte;
      s1_crc    <= crc8_byte(CRC_INIT, frame.data_high_byte, poly);
    end
  end

  // CRC over the low byte, compare and gate the word
  always_ff @(posedge clk) begin
    if (rst) begin
      mid_valid <= 1'b0;
    end else if (s2_ready) begin
      mid_valid <= s1_valid;
    end
    if (s2_ready && s1_valid) begin
      mid.action <= s1_action;
      mid.crc_ok <= (crc_full == s1_check);
      mid.raw    <= (crc_full == s1_check) ? {s1_high, s1_low} : 16'd0;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/scwc_scale.sv -----
`default_nettype none
module scwc_scale
  import scwc_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire word_t mid,
  input  wire logic  mid_valid,
  output logic       mid_ready,
  scwc_out_if.source result
);

  logic        s3_valid;
  logic        s3_action;
  logic        s3_ok;
  logic [15:0] s3_raw;
  logic [30:0] s3_prod;
  logic        s3_ready;
  logic        s4_ready;
  logic [14:0] span;
  logic [14:0] whole;

  assign s4_ready  = !result.valid || result.ready;
  assign s3_ready  = !s3_valid || s4_ready;
  assign mid_ready = s3_ready;
  assign span      = (mid.action == ACT_TEMP) ? TEMP_SPAN : HUM_SPAN;
  assign whole     = s3_prod[30:16];

  // Multiply by the span
  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (s3_ready) begin
      s3_valid <= mid_valid;
    end
    if (s3_ready && mid_valid) begin
      s3_action <= mid.action;
      s3_ok     <= mid.crc_ok;
      s3_raw    <= mid.raw;
      s3_prod   <= 31'(mid.raw) * 31'(span);
    end
  end

  // Floor, apply the offset for temperature and hold the result until transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (s4_ready) begin
      result.valid <= s3_valid;
    end
    if (s4_ready && s3_valid) begin
      result.crc_ok   <= s3_ok;
      result.raw_word <= s3_raw;
      result.scaled_hundredths <= (s3_action == ACT_TEMP) ?
                                  $signed(whole - TEMP_OFFSET) : $signed(whole);
    end
  end

endmodule
`default_nettype wire

// ----- verif/tb_sensor_word_crc_check_and_scale.sv -----
`timescale 1ns / 1ps
module tb_sensor_word_crc_check_and_scale;
  import scwc_pkg::*;

  localparam int CLK_PERIOD      = 12;
  localparam int RESET_CYCLES    = 7;
  localparam int HOLD_OFF_CYCLES = 120;
  localparam int SETTLE_CYCLES   = 8;
  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int TEMP_SPAN_HUND  = 17500;
  localparam int TEMP_OFFSET_HUND = 4500;
  localparam int HUM_SPAN_HUND   = 10000;

  typedef struct packed {
    logic               crc_ok;
    logic [15:0]        raw_word;
    logic signed [14:0] scaled;
  } reading_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_wr_en;
  logic [7:0] cfg_wr_data;

  scwc_in_if  frame_if ();
  scwc_out_if result_if ();

  sensor_word_crc_check_and_scale i_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .frame       (frame_if),
    .result      (result_if)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  reading_t   expected_readings[$];
  logic [7:0] crc_poly = CRC_POLY_RESET;
  bit         sender_idle = 1'b1;
  bit         sink_idle = 1'b1;
  bit         hold_results = 1'b0;
  int         mismatches = 0;
  int         frames_sent = 0;
  int         bad_crc_frames = 0;
  int         results_seen = 0;
  int         poly_writes = 0;
  int         quiet_cycles = 0;

  function automatic logic [7:0] sensor_crc8(input logic [7:0] hi, input logic [7:0] lo);
    logic [7:0]  crc;
    logic [15:0] bits;
    logic        fb;
    crc  = 8'hFF;
    bits = {hi, lo};
    for (int i = 15; i >= 0; i--) begin
      fb  = crc[7] ^ bits[i];
      crc = {crc[6:0], 1'b0} ^ (fb ? crc_poly : 8'h00);
    end
    return crc;
  endfunction

  function automatic reading_t predict_reading(input action_t act, input logic [7:0] hi,
                                               input logic [7:0] lo, input logic [7:0] chk);
    reading_t    r;
    int unsigned prod;
    int          value;
    r.crc_ok   = (sensor_crc8(hi, lo) == chk);
    r.raw_word = r.crc_ok ? {hi, lo} : 16'h0000;
    if (act == ACT_TEMP) begin
      prod  = TEMP_SPAN_HUND * r.raw_word;
      value = int'(prod >> 16) - TEMP_OFFSET_HUND;
    end else begin
      prod  = HUM_SPAN_HUND * r.raw_word;
      value = int'(prod >> 16);
    end
    r.scaled = value[14:0];
    return r;
  endfunction

  task automatic send_frame(input action_t act, input logic [7:0] hi, input logic [7:0] lo,
                            input logic [7:0] chk);
    int gap;
    gap = sender_idle ? $urandom_range(0, 7) : 0;
    if (gap > 0) begin
      frame_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    frame_if.valid          <= 1'b1;
    frame_if.action         <= act;
    frame_if.data_high_byte <= hi;
    frame_if.data_low_byte  <= lo;
    frame_if.crc_byte       <= chk;
    @(posedge clk);
    while (!frame_if.ready) @(posedge clk);
    expected_readings.push_back(predict_reading(act, hi, lo, chk));
    frames_sent++;
    if (chk != sensor_crc8(hi, lo)) bad_crc_frames++;
  endtask

  task automatic send_random_frame(input int good_pct);
    action_t    act;
    logic [7:0] hi;
    logic [7:0] lo;
    logic [7:0] chk;
    act = action_t'($urandom_range(0, 1));
    case ($urandom_range(0, 7))
      0: hi = 8'h00;
      1: hi = 8'hFF;
      default: hi = 8'($urandom_range(0, 255));
    endcase
    case ($urandom_range(0, 7))
      0: lo = 8'h00;
      1: lo = 8'hFF;
      default: lo = 8'($urandom_range(0, 255));
    endcase
    if ($urandom_range(0, 99) < good_pct) begin
      chk = sensor_crc8(hi, lo);
    end else if ($urandom_range(0, 1)) begin
      chk = sensor_crc8(hi, lo) ^ (8'h01 << $urandom_range(0, 7));
    end else begin
      chk = 8'($urandom_range(0, 255));
    end
    send_frame(act, hi, lo, chk);
  endtask

  task automatic wait_drained();
    frame_if.valid <= 1'b0;
    @(posedge clk);
    while (expected_readings.size() != 0) @(posedge clk);
  endtask

  task automatic write_polynomial(input logic [7:0] poly);
    wait_drained();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= poly;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    crc_poly = poly;
    poly_writes++;
  endtask

  task automatic test_directed_frames();
    logic [15:0] corner_words [7] = '{16'h0000, 16'hFFFF, 16'h8000, 16'h7FFF,
                                      16'h0001, 16'hA55A, 16'hBEEF};
    logic [7:0]  good;
    foreach (corner_words[i]) begin
      good = sensor_crc8(corner_words[i][15:8], corner_words[i][7:0]);
      send_frame(ACT_TEMP, corner_words[i][15:8], corner_words[i][7:0], good);
      send_frame(ACT_HUM, corner_words[i][15:8], corner_words[i][7:0], good);
    end
    good = sensor_crc8(8'hFF, 8'hFF);
    send_frame(ACT_TEMP, 8'hFF, 8'hFF, good ^ 8'h01);
    send_frame(ACT_HUM, 8'hFF, 8'hFF, good ^ 8'h80);
    send_frame(ACT_TEMP, 8'h12, 8'h34, 8'h00);
    send_frame(ACT_HUM, 8'h12, 8'h34, 8'hFF);
    send_frame(ACT_TEMP, 8'h00, 8'h00, 8'h00);
    wait_drained();
  endtask

  task automatic test_polynomial_extremes();
    logic [7:0] polys [5] = '{8'h00, 8'hFF, 8'h80, 8'h01, CRC_POLY_RESET};
    foreach (polys[i]) begin
      write_polynomial(polys[i]);
      repeat (20) send_random_frame(70);
    end
    wait_drained();
  endtask

  task automatic test_random_traffic();
    for (int n = 0; n < 300; n++) begin
      if (n % 75 == 0) write_polynomial(8'($urandom_range(0, 255)));
      send_random_frame(75);
    end
    wait_drained();
  endtask

  task automatic test_full_rate();
    sender_idle = 1'b0;
    sink_idle   = 1'b0;
    repeat (60) send_random_frame(75);
    wait_drained();
    sender_idle = 1'b1;
    sink_idle   = 1'b1;
  endtask

  task automatic test_output_hold_off();
    sender_idle  = 1'b0;
    hold_results = 1'b1;
    repeat (40) send_random_frame(75);
    wait_drained();
    sender_idle = 1'b1;
  endtask

  task automatic test_drain_between_bursts();
    repeat (5) begin
      repeat (8) send_random_frame(75);
      wait_drained();
    end
  endtask

  initial begin : result_sink
    int stall;
    result_if.ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (hold_results) begin
        hold_results = 1'b0;
        result_if.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end
      stall = sink_idle ? $urandom_range(0, 7) : 0;
      if (stall > 0) begin
        result_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      result_if.ready <= 1'b1;
      @(posedge clk);
      while (!result_if.valid && !hold_results) @(posedge clk);
    end
  end

  always @(posedge clk) begin : result_check
    reading_t want;
    if (!rst && result_if.valid && result_if.ready) begin
      if (expected_readings.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result, expected none, got crc_ok=%0b raw=%h scaled=%0d",
                 $time, result_if.crc_ok, result_if.raw_word, result_if.scaled_hundredths);
      end else begin
        want = expected_readings.pop_front();
        results_seen++;
        if (result_if.crc_ok !== want.crc_ok) begin
          mismatches++;
          $display("%0t: crc_ok mismatch, expected %0b, got %0b",
                   $time, want.crc_ok, result_if.crc_ok);
        end
        if (result_if.raw_word !== want.raw_word) begin
          mismatches++;
          $display("%0t: raw_word mismatch, expected %h, got %h",
                   $time, want.raw_word, result_if.raw_word);
        end
        if (result_if.scaled_hundredths !== want.scaled) begin
          mismatches++;
          $display("%0t: scaled_hundredths mismatch, expected %0d, got %0d",
                   $time, want.scaled, result_if.scaled_hundredths);
        end
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if (rst || (frame_if.valid && frame_if.ready) || (result_if.valid && result_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no transfer for %0d cycles, %0d results outstanding",
               $time, quiet_cycles, expected_readings.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin : test_sequence
    rst                     <= 1'b1;
    cfg_wr_en               <= 1'b0;
    cfg_wr_data             <= 8'h00;
    frame_if.valid          <= 1'b0;
    frame_if.action         <= ACT_TEMP;
    frame_if.data_high_byte <= 8'h00;
    frame_if.data_low_byte  <= 8'h00;
    frame_if.crc_byte       <= 8'h00;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_frames();
    test_polynomial_extremes();
    test_random_traffic();
    test_full_rate();
    test_output_hold_off();
    test_drain_between_bursts();
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Sent %0d frames (%0d with a bad checksum), temperature and humidity,",
             frames_sent, bad_crc_frames);
    $display("over %0d polynomial writes; %0d results checked, %0d mismatches",
             poly_writes, results_seen, mismatches);
    if (mismatches == 0 && expected_readings.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+rtl/core
rtl/core/scwc_pkg.sv
rtl/core/scwc_in_if.sv
rtl/core/scwc_out_if.sv
rtl/core/scwc_crc_front.sv
rtl/core/scwc_scale.sv
rtl/core/sensor_word_crc_check_and_scale.sv
verif/tb_sensor_word_crc_check_and_scale.sv
